// ===== rtl/ucd_pkg.sv =====
// Shared types, code point constants and lead byte helpers for the UTF-8 decoder.
`timescale 1ns / 1ps

package ucd_pkg;

    localparam logic [20:0] CpReplace  = 21'h00FFFD;
    localparam logic [20:0] CpWordJoin = 21'h002060;
    localparam logic [20:0] CpByteMark = 21'h00FEFF;
    localparam logic [20:0] CpZeroSpc  = 21'h00200B;

    // One result item.
    typedef struct packed {
        logic [20:0] code_point;
        logic        point_valid;
        logic        end_of_text;
    } t_result;

    // Control from the decode logic to the sequencing in the top level.
    typedef struct packed {
        logic [1:0] res_count;   // results produced, 0 to 3
        logic       hold_byte;   // store the new byte at the current fill level
        logic [1:0] next_count;  // held byte count after this item
    } t_dec_ctl;

    // Sequence length from the lead byte; 0 marks an invalid lead.
    function automatic logic [2:0] seq_len(input logic [7:0] c);
        logic [2:0] len;
        if (c[7] == 1'b0) begin
            len = 3'd1;
        end else if ((c & 8'hE0) == 8'hC0) begin
            len = 3'd2;
        end else if ((c & 8'hF0) == 8'hE0) begin
            len = 3'd3;
        end else if ((c & 8'hF8) == 8'hF0) begin
            len = 3'd4;
        end else begin
            len = 3'd0;
        end
        return len;
    endfunction

    // Code points that are dropped from the output.
    function automatic logic is_hidden(input logic [20:0] cp);
        return (cp == CpWordJoin) || (cp == CpByteMark) || (cp == CpZeroSpc);
    endfunction

endpackage

// ===== rtl/ucd_decode.sv =====
// Combinational decode of held bytes plus one new byte into up to three results.
`timescale 1ns / 1ps

module ucd_decode (
    input  logic [7:0]        i_held [3],
    input  logic [1:0]        i_held_count,
    input  logic [7:0]        i_text_byte,
    input  logic              i_final_byte,
    output ucd_pkg::t_result  o_res [3],
    output ucd_pkg::t_dec_ctl o_ctl
);
    import ucd_pkg::*;

    logic [7:0]  buf_b  [4];
    logic [2:0]  n_bytes;
    logic [2:0]  len_at [4];
    logic [20:0] cp_at  [4];
    logic [2:0]  adv_at [4];
    logic [20:0] cand_cp [4];
    logic        cand_v  [4];
    logic        hold;

    // Pending bytes: held bytes, then the new one.
    always_comb begin
        buf_b[0] = (i_held_count == 2'd0) ? i_text_byte : i_held[0];
        buf_b[1] = (i_held_count == 2'd1) ? i_text_byte : i_held[1];
        buf_b[2] = (i_held_count == 2'd2) ? i_text_byte : i_held[2];
        buf_b[3] = i_text_byte;
        n_bytes  = {1'b0, i_held_count} + 3'd1;
    end

    // Decode a sequence starting at each position independently.
    always_comb begin
        logic [2:0] rem;
        logic [1:0] i1, i2, i3;
        for (int p = 0; p < 4; p++) begin
            rem       = n_bytes - 3'(p);
            i1        = 2'(p + 1);
            i2        = 2'(p + 2);
            i3        = 2'(p + 3);
            len_at[p] = seq_len(buf_b[p]);
            adv_at[p] = 3'd1;
            cp_at[p]  = CpReplace;
            if (len_at[p] == 3'd1) begin
                cp_at[p] = {13'd0, buf_b[p]};
            end else if (len_at[p] >= 3'd2 && n_bytes > 3'(p) && rem >= len_at[p]) begin
                adv_at[p] = len_at[p];
                case (len_at[p])
                    3'd2: cp_at[p] = {10'd0, buf_b[p][4:0], buf_b[i1][5:0]};
                    3'd3: cp_at[p] = {5'd0, buf_b[p][3:0], buf_b[i1][5:0], buf_b[i2][5:0]};
                    default: cp_at[p] = {buf_b[p][2:0], buf_b[i1][5:0], buf_b[i2][5:0],
                                         buf_b[i3][5:0]};
                endcase
            end
        end
    end

    // Walk the pending bytes; a non-final byte yields at most the first sequence.
    // The position is one bit wider than the byte count so it never wraps past the end.
    always_comb begin
        logic [3:0] pos;
        hold = (len_at[0] >= 3'd2) && (n_bytes < len_at[0]) && !i_final_byte;
        pos  = 4'd0;
        for (int j = 0; j < 4; j++) begin
            cand_v[j]  = (pos < {1'b0, n_bytes}) && (i_final_byte || (j == 0 && !hold));
            cand_cp[j] = cp_at[pos[1:0]];
            pos        = pos + {1'b0, adv_at[pos[1:0]]};
        end
    end

    // Drop hidden code points, keep the first three, mark the end of text.
    always_comb begin
        logic [2:0] k;
        k = 3'd0;
        for (int s = 0; s < 3; s++) begin
            o_res[s] = '0;
        end
        for (int j = 0; j < 4; j++) begin
            if (cand_v[j] && !is_hidden(cand_cp[j]) && k < 3'd3) begin
                o_res[k[1:0]].code_point  = cand_cp[j];
                o_res[k[1:0]].point_valid = 1'b1;
                k = k + 3'd1;
            end
        end
        if (i_final_byte) begin
            if (k == 3'd0) begin
                o_res[0].end_of_text = 1'b1;
                k = 3'd1;
            end else begin
                o_res[2'(k - 3'd1)].end_of_text = 1'b1;
            end
        end
        o_ctl.res_count  = k[1:0];
        o_ctl.hold_byte  = hold;
        o_ctl.next_count = hold ? n_bytes[1:0] : 2'd0;
    end

endmodule

// ===== rtl/utf8_codepoint_decoder_unit.sv =====
// Top level of the UTF-8 code point decoder: input register, decode, result queue.
// An accepted byte waits in the input register; its decoded results go to the result queue.
// Throughput: one byte per cycle while the results fit in the queue; a final byte that ends a
// cut sequence yields up to three results, drained one per unstalled cycle from the three-entry result queue.
// Reset (synchronous, active low) empties the input register, the queue and the held count.
`timescale 1ns / 1ps

module utf8_codepoint_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input byte channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_text_byte,
    input  logic        i_final_byte,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [20:0] o_code_point,
    output logic        o_point_valid,
    output logic        o_end_of_text
);
    import ucd_pkg::*;

    // Input register: the item waiting to be decoded.
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_final;

    // Bytes of an unfinished sequence and how many there are.
    logic [7:0] r_held [3];
    logic [1:0] r_held_count;

    // Result queue; entry 0 is on the output ports.
    t_result    r_q [3];
    logic [1:0] r_q_count;
    t_result    n_q [3];
    logic [1:0] n_q_count;

    t_result    dec_res [3];
    t_dec_ctl   dec_ctl;
    logic       pop;
    logic       advance;
    logic [1:0] base;
    logic       in_take;

    ucd_decode u_decode (
        .i_held       (r_held),
        .i_held_count (r_held_count),
        .i_text_byte  (r_in_byte),
        .i_final_byte (r_in_final),
        .o_res        (dec_res),
        .o_ctl        (dec_ctl)
    );

    // Output side: pop the head when the receiver is not stalling.
    assign o_valid       = (r_q_count != 2'd0);
    assign o_code_point  = r_q[0].code_point;
    assign o_point_valid = r_q[0].point_valid;
    assign o_end_of_text = r_q[0].end_of_text;
    assign pop           = o_valid && !i_stall;

    // Advance the held item once its results fit behind what stays in the queue.
    assign base    = r_q_count - {1'b0, pop};
    assign advance = r_in_valid
                     && ({1'b0, base} + {1'b0, dec_ctl.res_count} <= 3'd3);

    // Stall the input only while the input register is full and cannot move on.
    assign o_stall = r_in_valid && !advance;
    assign in_take = i_valid && !o_stall;

    // Next queue contents: shift out the popped head, append new results.
    always_comb begin
        logic [1:0] src;
        logic [1:0] off;
        for (int s = 0; s < 3; s++) begin
            src = 2'(s) + {1'b0, pop};
            off = 2'(s) - base;
            if (2'(s) < base) begin
                n_q[s] = r_q[src];
            end else if (advance && off < dec_ctl.res_count) begin
                n_q[s] = dec_res[off];
            end else begin
                n_q[s] = r_q[s];
            end
        end
        n_q_count = advance ? base + dec_ctl.res_count : base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_held_count <= 2'd0;
            r_q_count    <= 2'd0;
        end else begin
            r_q_count <= n_q_count;
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_held_count <= dec_ctl.next_count;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte  <= i_text_byte;
            r_in_final <= i_final_byte;
        end
        if (advance && dec_ctl.hold_byte) begin
            r_held[r_held_count] <= r_in_byte;
        end
        r_q <= n_q;
    end

endmodule

// ===== sim/utf8_decode_checker.sv =====
// Checker for the UTF-8 decoder: watches both channels, predicts code points, compares results.
`timescale 1ns / 1ps

module utf8_decode_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_text_byte,
    input  logic        i_final_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [20:0] i_code_point,
    input  logic        i_point_valid,
    input  logic        i_end_of_text,
    output int          o_mismatches,
    output int          o_outstanding
);
    import ucd_pkg::*;

    // Bytes of an unfinished sequence; only entries below held_n are ever read.
    logic [7:0]  held_seq [3];
    int          held_n;
    t_result     expected_points [$];
    int          mismatch_count = 0;

    function automatic int lead_length(input logic [7:0] c);
        casez (c)
            8'b0???????: return 1;
            8'b110?????: return 2;
            8'b1110????: return 3;
            8'b11110???: return 4;
            default:     return 0;
        endcase
    endfunction

    function automatic logic [20:0] assemble_point(input logic [31:0] seq, input int pos,
                                                   input int len);
        logic [7:0]  lead;
        logic [20:0] cp;
        int          i;
        lead = seq[8*pos +: 8];
        case (len)
            2:       cp = {13'd0, lead & 8'h1F};
            3:       cp = {13'd0, lead & 8'h0F};
            default: cp = {13'd0, lead & 8'h07};
        endcase
        for (i = 1; i < len; i++) begin
            cp = {cp[14:0], seq[8*(pos+i) +: 6]};
        end
        return cp;
    endfunction

    // Append one result to the tail of the expected queue.
    function automatic void add_expected(input t_result r);
        expected_points.insert(expected_points.size(), r);
    endfunction

    // Advance the decoder state by one byte and queue the results it causes.
    function automatic void decode_byte(input logic [7:0] b, input logic fin);
        logic [31:0] pend;
        logic [20:0] raw [4];
        logic [20:0] kept [3];
        int          nraw;
        int          nkept;
        int          n;
        int          len;
        int          pos;
        int          i;
        t_result     r;
        pend = '0;
        for (i = 0; i < held_n; i++) begin
            pend[8*i +: 8] = held_seq[i];
        end
        pend[8*held_n +: 8] = b;
        n    = held_n + 1;
        nraw = 0;
        if (!fin) begin
            len = lead_length(pend[7:0]);
            if (len == 1) begin
                raw[0] = {13'd0, pend[7:0]};
                nraw   = 1;
                held_n = 0;
            end else if (len == 0) begin
                raw[0] = CpReplace;
                nraw   = 1;
                held_n = 0;
            end else if (n >= len) begin
                raw[0] = assemble_point(pend, 0, len);
                nraw   = 1;
                held_n = 0;
            end else begin
                held_seq[held_n] = b;
                held_n           = n;
            end
        end else begin
            // Redecode whatever is pending as a string of its own.
            pos = 0;
            while (pos < n) begin
                len = lead_length(pend[8*pos +: 8]);
                if (len == 1) begin
                    raw[nraw] = {13'd0, pend[8*pos +: 8]};
                    pos++;
                end else if (len >= 2 && n - pos >= len) begin
                    raw[nraw] = assemble_point(pend, pos, len);
                    pos += len;
                end else begin
                    raw[nraw] = CpReplace;
                    pos++;
                end
                nraw++;
            end
            held_n = 0;
        end
        // Drop invisible code points.
        nkept = 0;
        for (i = 0; i < nraw; i++) begin
            if (raw[i] != CpWordJoin && raw[i] != CpByteMark && raw[i] != CpZeroSpc
                && nkept < 3) begin
                kept[nkept] = raw[i];
                nkept++;
            end
        end
        for (i = 0; i < nkept; i++) begin
            r.code_point  = kept[i];
            r.point_valid = 1'b1;
            r.end_of_text = fin && (i == nkept - 1);
            add_expected(r);
        end
        if (fin && nkept == 0) begin
            r.code_point  = '0;
            r.point_valid = 1'b0;
            r.end_of_text = 1'b1;
            add_expected(r);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            held_n = 0;
            expected_points.delete();
        end else begin
            // Results leave before new bytes are counted: a result never stems from this edge.
            if (i_out_valid && !i_out_stall) begin
                if (expected_points.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result with none expected, actual code_point %h", $time,
                             i_code_point);
                end else begin
                    want = expected_points.pop_front();
                    if (i_code_point !== want.code_point) begin
                        mismatch_count++;
                        $display("%0t: code_point expected %h, actual %h", $time,
                                 want.code_point, i_code_point);
                    end
                    if (i_point_valid !== want.point_valid) begin
                        mismatch_count++;
                        $display("%0t: point_valid expected %b, actual %b", $time,
                                 want.point_valid, i_point_valid);
                    end
                    if (i_end_of_text !== want.end_of_text) begin
                        mismatch_count++;
                        $display("%0t: end_of_text expected %b, actual %b", $time,
                                 want.end_of_text, i_end_of_text);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                decode_byte(i_text_byte, i_final_byte);
            end
        end
        o_outstanding <= expected_points.size();
        o_mismatches  <= mismatch_count;
    end

endmodule

// ===== sim/tb_utf8_codepoint_decoder_unit.sv =====
// Testbench top for the UTF-8 decoder: byte stimulus, result stalls, watchdog and verdict.
`timescale 1ns / 1ps

module tb_utf8_codepoint_decoder_unit;

    localparam int ItemTarget    = 370;   // stop offering bytes after this many
    localparam int DrainFrom     = 330;   // no idling on either side from here on
    localparam int HoldOffAt     = 120;   // start the long result hold-off here
    localparam int HoldOffCycles = 80;
    localparam int WatchdogLimit = 2000;  // cycles with no item moving on either channel
    localparam int TailCycles    = 8;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  text_byte;
    logic        final_byte;
    logic        out_valid;
    logic        out_stall;
    logic [20:0] code_point;
    logic        point_valid;
    logic        end_of_text;

    int          mismatches;
    int          outstanding;

    // Byte count of the sender, and the flags it shares with the result sink.
    int          items_sent;
    logic        hold_request;
    logic        drain;

    // Bytes of the string being sent.
    logic [7:0]  text_buf [$];

    utf8_codepoint_decoder_unit dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (in_valid),
        .o_stall      (in_stall),
        .i_text_byte  (text_byte),
        .i_final_byte (final_byte),
        .o_valid      (out_valid),
        .i_stall      (out_stall),
        .o_code_point (code_point),
        .o_point_valid(point_valid),
        .o_end_of_text(end_of_text)
    );

    utf8_decode_checker point_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_text_byte  (text_byte),
        .i_final_byte (final_byte),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_code_point (code_point),
        .i_point_valid(point_valid),
        .i_end_of_text(end_of_text),
        .o_mismatches (mismatches),
        .o_outstanding(outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Append one byte to the string being built.
    function automatic void add_byte(input logic [7:0] b);
        text_buf.insert(text_buf.size(), b);
    endfunction

    // Offer one byte and hold it until the block takes it, then maybe idle a while.
    task automatic push_byte(input logic [7:0] b, input logic fin);
        int gap;
        in_valid   <= 1'b1;
        text_byte  <= b;
        final_byte <= fin;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
        if (items_sent >= HoldOffAt) hold_request = 1'b1;
        if (items_sent >= DrainFrom) drain = 1'b1;
        // Keep a calm stretch in every 64 items; elsewhere drop valid for short bursts.
        if (!drain && (items_sent % 64) >= 16 && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 7);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Build a string of mostly well-formed characters with random content and send it,
    // the last byte flagged as final. Some strings are pure noise, some end cut short.
    task automatic send_random_text();
        int         nchars;
        int         kind;
        int         len;
        int         c;
        int         i;
        int         cut;
        logic [7:0] lead;
        text_buf.delete();
        len = 1;
        if ($urandom_range(0, 5) == 0) begin
            nchars = $urandom_range(1, 8);
            repeat (nchars) add_byte(8'($urandom_range(0, 255)));
        end else begin
            nchars = $urandom_range(1, 10);
            for (c = 0; c < nchars; c++) begin
                kind = $urandom_range(0, 19);
                len  = 1;
                if (kind <= 5 || kind >= 18) begin
                    add_byte(8'($urandom_range(0, 127)));
                end else if (kind <= 14) begin
                    len = (kind <= 8) ? 2 : ((kind <= 11) ? 3 : 4);
                    case (len)
                        2:       lead = 8'hC0 | 8'($urandom_range(0, 31));
                        3:       lead = 8'hE0 | 8'($urandom_range(0, 15));
                        default: lead = 8'hF0 | 8'($urandom_range(0, 7));
                    endcase
                    add_byte(lead);
                    // Mostly proper continuation bytes; now and then anything at all.
                    for (i = 1; i < len; i++) begin
                        if ($urandom_range(0, 7) == 0) begin
                            add_byte(8'($urandom_range(0, 255)));
                        end else begin
                            add_byte(8'h80 | 8'($urandom_range(0, 63)));
                        end
                    end
                end else if (kind == 15) begin
                    // An invisible code point: word joiner, byte order mark, zero width space.
                    len = 3;
                    case ($urandom_range(0, 2))
                        0: begin
                            add_byte(8'hE2);
                            add_byte(8'h81);
                            add_byte(8'hA0);
                        end
                        1: begin
                            add_byte(8'hEF);
                            add_byte(8'hBB);
                            add_byte(8'hBF);
                        end
                        default: begin
                            add_byte(8'hE2);
                            add_byte(8'h80);
                            add_byte(8'h8B);
                        end
                    endcase
                end else if (kind == 16) begin
                    if ($urandom_range(0, 1) == 0) begin
                        add_byte(8'h80 | 8'($urandom_range(0, 63)));
                    end else begin
                        add_byte(8'hF8 | 8'($urandom_range(0, 7)));
                    end
                end else begin
                    add_byte(8'($urandom_range(0, 255)));
                end
            end
            // Cut the last multi-byte character short so the string ends inside it.
            if (len > 1 && $urandom_range(0, 3) == 0) begin
                cut = $urandom_range(1, len - 1);
                repeat (cut) text_buf.delete(text_buf.size() - 1);
            end
        end
        for (i = 0; i < text_buf.size(); i++) begin
            push_byte(text_buf[i], i == text_buf.size() - 1);
        end
    endtask

    initial begin : stimulus
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        text_byte    <= 8'h00;
        final_byte   <= 1'b0;
        items_sent   = 0;
        hold_request = 1'b0;
        drain        = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // ASCII extremes.
        push_byte(8'h00, 1'b0);
        push_byte(8'h7F, 1'b0);
        // Largest two byte point, U+07FF.
        push_byte(8'hDF, 1'b0);
        push_byte(8'hBF, 1'b0);
        // Replacement character itself, three bytes.
        push_byte(8'hEF, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hBD, 1'b0);
        // Largest four byte form, all code point bits set.
        push_byte(8'hF7, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hBF, 1'b0);
        // Invalid leads: a stray continuation byte and an all-ones byte.
        push_byte(8'h80, 1'b0);
        push_byte(8'hFF, 1'b0);
        // Word joiner is dropped.
        push_byte(8'hE2, 1'b0);
        push_byte(8'hA1 ^ 8'h20, 1'b0);
        push_byte(8'hA0, 1'b0);
        // Byte order mark on the final byte: nothing to emit, so a bare end marker.
        push_byte(8'hEF, 1'b0);
        push_byte(8'hBB, 1'b0);
        push_byte(8'hBF, 1'b1);
        // String ends inside a four byte sequence: three replacement results.
        push_byte(8'hF0, 1'b0);
        push_byte(8'h9F, 1'b0);
        push_byte(8'h98, 1'b1);
        // Cut lead followed by a plain byte that is decoded again as a new lead.
        push_byte(8'hE2, 1'b0);
        push_byte(8'h41, 1'b1);
        // A lone two byte lead as the final byte.
        push_byte(8'hC3, 1'b1);
        // A complete four byte character ends the string.
        push_byte(8'hF0, 1'b0);
        push_byte(8'h9F, 1'b0);
        push_byte(8'h98, 1'b0);
        push_byte(8'h80, 1'b1);

        while (items_sent < ItemTarget) send_random_text();
        in_valid <= 1'b0;

        // Let the checker count the last byte, drain, then allow for a late extra result.
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (TailCycles) @(posedge clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb_utf8_codepoint_decoder_unit: done, clean");
        end else begin
            $display("tb_utf8_codepoint_decoder_unit: done, errors");
        end
        $finish;
    end

    // Result side: random stall bursts with calm windows, one long hold-off so the
    // block fills up and pushes back on the byte channel, and none during the drain.
    initial begin : result_sink
        int   burst;
        int   cyc;
        logic held_off;
        out_stall <= 1'b0;
        held_off  = 1'b0;
        cyc       = 0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            cyc++;
            if (hold_request && !held_off) begin
                held_off = 1'b1;
                out_stall <= 1'b1;
                repeat (HoldOffCycles) @(posedge clk);
                out_stall <= 1'b0;
            end else if (!drain && (cyc % 100) >= 30 && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 7);
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Count cycles in which no item moves on either channel; give up past the limit.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WatchdogLimit) begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb_utf8_codepoint_decoder_unit: done, errors");
        $finish;
    end

endmodule
